// ===== design/sust_pkg.sv =====
// shared types and constants for the sorted unique set table
// request and response payloads, status codes, controller states, command/status bundles
// no dependencies
package sust_pkg;

   localparam int REC_WIDTH        = 32;
   localparam int MAX_NUMBER_WIDTH = 64;
   localparam int INDEX_OUT_WIDTH  = 6;
   localparam int COUNT_OUT_WIDTH  = 7;

   // request codes; any other code is a lookup
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [REC_WIDTH-1:0] record_number;
   } req_item_type;

   typedef struct packed {
      status_type                 status;
      logic [INDEX_OUT_WIDTH-1:0] found_index;
      logic [COUNT_OUT_WIDTH-1:0] entry_count;
      logic                       modified;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROBE,
      S_COMPARE,
      S_VERIFY,
      S_SHIFT,
      S_DRAIN,
      S_COMMIT,
      S_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic probe;
      logic narrow;
      logic check;
      logic decide;
      logic shift;
      logic commit;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic search_open;
      logic mutate_ins;
      logic mutate_rem;
      logic shift_more;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== design/sust_ctrl.sv =====
// controller state machine for the sorted unique set table
// sequences search, verify, shift and commit; depends on sust_pkg
module sust_ctrl import sust_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PROBE;
         end
         S_PROBE: begin
            state_in = stat.search_open ? S_COMPARE : S_VERIFY;
         end
         S_COMPARE: begin
            state_in = S_PROBE;
         end
         S_VERIFY: begin
            state_in = (stat.mutate_ins || stat.mutate_rem) ? S_SHIFT : S_RESULT;
         end
         S_SHIFT: begin
            if (!stat.shift_more) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_PROBE: begin
            cmd.probe = stat.search_open;
            cmd.check = !stat.search_open;
         end
         S_COMPARE: begin
            cmd.narrow = 1'b1;
         end
         S_VERIFY: begin
            cmd.decide = 1'b1;
         end
         S_SHIFT: begin
            cmd.shift = stat.shift_more;
         end
         S_DRAIN: begin
            cmd = '0;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
         end
         S_RESULT: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== design/sust_dpath.sv =====
// datapath for the sorted unique set table: entry memory, search bounds,
// shift pointer, counters and the response register; depends on sust_pkg
module sust_dpath import sust_pkg::*; #(
   parameter int CAPACITY     = 64,
   parameter int NUMBER_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_data,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [NUMBER_WIDTH-1:0] mem [CAPACITY];

   logic [1:0]              op_ff;
   logic [NUMBER_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]           lo_ff, hi_ff, mid_ff, mid_in, ptr_ff, ptr_in, count_ff;
   logic                    modified_ff;
   logic [NUMBER_WIDTH-1:0] rd_data_ff;
   logic                    pend_ff;
   logic [AW-1:0]           pend_addr_ff;
   status_type              res_status_ff, dec_status;
   logic [INDEX_OUT_WIDTH-1:0] res_index_ff, dec_index;
   logic                    rsp_valid_ff;
   rsp_item_type            rsp_data_ff;

   logic [MAX_NUMBER_WIDTH-1:0] rec_wide;
   logic [CW:0]             mid_sum, ptr_up;
   logic [CW-1:0]           ptr_dn;
   logic [CW+INDEX_OUT_WIDTH-1:0] lo_ext;
   logic [CW+COUNT_OUT_WIDTH-1:0] count_ext;
   logic                    is_ins, is_rem, full, present, mut_ins, mut_rem;
   logic [AW-1:0]           rd_addr, shift_addr, wr_addr;
   logic                    rd_en, wr_en;
   logic [NUMBER_WIDTH-1:0] wr_data;

   // bits above the stored width are dropped
   assign rec_wide = {{(MAX_NUMBER_WIDTH-REC_WIDTH){1'b0}}, req_data.record_number};
   assign key_in   = rec_wide[NUMBER_WIDTH-1:0];

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in  = mid_sum[CW:1];

   assign is_ins  = (op_ff == REQ_INSERT);
   assign is_rem  = (op_ff == REQ_REMOVE);
   assign full    = (count_ff >= CW'(CAPACITY));
   assign present = (lo_ff < count_ff) && (rd_data_ff == key_ff);
   assign lo_ext  = {{INDEX_OUT_WIDTH{1'b0}}, lo_ff};
   assign count_ext = {{COUNT_OUT_WIDTH{1'b0}}, count_ff};

   always_comb begin
      dec_status = ST_OK;
      dec_index  = '0;
      mut_ins    = 1'b0;
      mut_rem    = 1'b0;
      if (is_ins) begin
         if (full) begin
            dec_status = ST_FULL;
         end else if (present) begin
            dec_status = ST_DUP;
            dec_index  = lo_ext[INDEX_OUT_WIDTH-1:0];
         end else begin
            mut_ins   = 1'b1;
            dec_index = lo_ext[INDEX_OUT_WIDTH-1:0];
         end
      end else if (is_rem) begin
         if (!present) begin
            dec_status = ST_MISSING;
         end else begin
            mut_rem   = 1'b1;
            dec_index = lo_ext[INDEX_OUT_WIDTH-1:0];
         end
      end else begin
         if (present) begin
            dec_index = lo_ext[INDEX_OUT_WIDTH-1:0];
         end else begin
            dec_status = ST_MISSING;
         end
      end
   end

   // insert moves entries up walking down from the top, remove moves them down walking up
   assign ptr_dn     = ptr_ff - 1'b1;
   assign ptr_up     = {1'b0, ptr_ff} + 1'b1;
   assign shift_addr = is_ins ? ptr_dn[AW-1:0] : ptr_up[AW-1:0];
   assign ptr_in     = is_ins ? ptr_dn : ptr_up[CW-1:0];

   assign stat.search_open = (lo_ff < hi_ff);
   assign stat.mutate_ins  = mut_ins;
   assign stat.mutate_rem  = mut_rem;
   assign stat.shift_more  = is_ins ? (ptr_ff > lo_ff) : (ptr_up < {1'b0, count_ff});
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.shift) begin
         rd_addr = shift_addr;
      end else if (cmd.check) begin
         rd_addr = lo_ff[AW-1:0];
      end else begin
         rd_addr = mid_in[AW-1:0];
      end
   end
   assign rd_en = cmd.probe | cmd.check | cmd.shift;

   // a read moved entry is written back in the cycle after its read
   assign wr_en   = pend_ff | (cmd.commit & is_ins);
   assign wr_addr = pend_ff ? pend_addr_ff : lo_ff[AW-1:0];
   assign wr_data = pend_ff ? rd_data_ff : key_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff        <= '0;
         hi_ff        <= '0;
         count_ff     <= '0;
         modified_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.shift;
         if (cmd.load) begin
            lo_ff <= '0;
            hi_ff <= count_ff;
         end else if (cmd.narrow) begin
            if (key_ff <= rd_data_ff) begin
               hi_ff <= mid_ff;
            end else begin
               lo_ff <= mid_ff + 1'b1;
            end
         end
         if (cmd.commit) begin
            count_ff    <= is_ins ? count_ff + 1'b1 : count_ff - 1'b1;
            modified_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.req_type;
         key_ff <= key_in;
      end
      if (cmd.probe) mid_ff <= mid_in;
      if (cmd.decide) begin
         res_status_ff <= dec_status;
         res_index_ff  <= dec_index;
         ptr_ff        <= is_ins ? count_ff : lo_ff;
      end
      if (cmd.shift) begin
         ptr_ff       <= ptr_in;
         pend_addr_ff <= ptr_ff[AW-1:0];
      end
      if (cmd.emit) begin
         rsp_data_ff.status      <= res_status_ff;
         rsp_data_ff.found_index <= res_index_ff;
         rsp_data_ff.entry_count <= count_ext[COUNT_OUT_WIDTH-1:0];
         rsp_data_ff.modified    <= modified_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("search bounds crossed");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == REQ_REMOVE) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not drop the count by one");
`endif

endmodule

// ===== design/sorted_unique_set_table.sv =====
// top level of the sorted unique set table
// joins sust_ctrl and sust_dpath; depends on sust_pkg
//
//   channel   ports                           payload
//   request   req_valid / req_stall (in)      req_data: req_type, record_number
//   response  rsp_valid / rsp_stall (out)     rsp_data: status, found_index,
//                                             entry_count, modified
//
// one request at a time; a lookup runs a binary search of up to ceil(log2(count+1))
// probes through the single read port of the entry memory
// a successful insert or remove then shifts the entries behind the found index; the shift
// runs one entry per cycle through that port
// reset is synchronous and empties the table; entry memory is not cleared
// a new request is taken while the previous response waits under rsp_stall
module sorted_unique_set_table import sust_pkg::*; #(
   parameter int CAPACITY     = 64,
   parameter int NUMBER_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sust_dpath #(
      .CAPACITY     (CAPACITY),
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/sorted_unique_set_table_tb.sv =====
// testbench for sorted_unique_set_table: directed and random insert, remove and lookup
// requests under random request gaps and response stalls, checked by a scoreboard class
// that keeps its own sorted copy of the table; depends on sust_pkg and the design sources
`timescale 1ns / 1ps

class sorted_set_scoreboard;
   int unsigned capacity;
   logic [sust_pkg::REC_WIDTH-1:0] entries[$];
   bit modified;
   sust_pkg::rsp_item_type expected_rsp[$];
   int unsigned errors;

   function new(int unsigned depth);
      capacity = depth;
      modified = 1'b0;
      errors = 0;
   endfunction

   function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endfunction

   function int unsigned pending();
      return expected_rsp.size();
   endfunction

   // applies one accepted request to the table copy and queues its response
   function void note_request(sust_pkg::req_item_type item);
      int lo;
      int hi;
      int mid;
      int count;
      bit present;
      sust_pkg::rsp_item_type rsp;
      lo = 0;
      hi = entries.size();
      // first entry not below the number
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (item.record_number <= entries[mid]) hi = mid;
         else lo = mid + 1;
      end
      present = (lo < entries.size()) && (entries[lo] == item.record_number);
      rsp.status = sust_pkg::ST_OK;
      rsp.found_index = '0;
      case (item.req_type)
         sust_pkg::REQ_INSERT: begin
            // full wins over duplicate
            if (entries.size() >= capacity) begin
               rsp.status = sust_pkg::ST_FULL;
            end else if (present) begin
               rsp.status = sust_pkg::ST_DUP;
               rsp.found_index = lo[sust_pkg::INDEX_OUT_WIDTH-1:0];
            end else begin
               entries.insert(lo, item.record_number);
               modified = 1'b1;
               rsp.found_index = lo[sust_pkg::INDEX_OUT_WIDTH-1:0];
            end
         end
         sust_pkg::REQ_REMOVE: begin
            if (!present) begin
               rsp.status = sust_pkg::ST_MISSING;
            end else begin
               entries.delete(lo);
               modified = 1'b1;
               rsp.found_index = lo[sust_pkg::INDEX_OUT_WIDTH-1:0];
            end
         end
         default: begin
            if (present) rsp.found_index = lo[sust_pkg::INDEX_OUT_WIDTH-1:0];
            else rsp.status = sust_pkg::ST_MISSING;
         end
      endcase
      count = entries.size();
      rsp.entry_count = count[sust_pkg::COUNT_OUT_WIDTH-1:0];
      rsp.modified = modified;
      expected_rsp.push_back(rsp);
   endfunction

   function void check_response(sust_pkg::rsp_item_type got);
      sust_pkg::rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         report($sformatf("unexpected response: status=%0d index=%0d count=%0d modified=%0d",
                          got.status, got.found_index, got.entry_count, got.modified));
         return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status || got.found_index !== want.found_index ||
          got.entry_count !== want.entry_count || got.modified !== want.modified) begin
         report($sformatf({"response mismatch: expected status=%0d index=%0d count=%0d ",
                           "modified=%0d, got status=%0d index=%0d count=%0d modified=%0d"},
                          want.status, want.found_index, want.entry_count, want.modified,
                          got.status, got.found_index, got.entry_count, got.modified));
      end
   endfunction

   function void report_leftovers();
      if (expected_rsp.size() != 0)
         report($sformatf("%0d responses never arrived", expected_rsp.size()));
   endfunction
endclass

module sorted_unique_set_table_tb;
   import sust_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int DRAIN_CYCLES = 120;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_SPARE  = 2'd3;   // unused code, decodes as lookup

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int unsigned cycle_count   = 0;
   sorted_set_scoreboard board;

   sorted_unique_set_table #(
      .CAPACITY(TABLE_DEPTH),
      .NUMBER_WIDTH(32)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_unique_set_table_tb: done, errors");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [31:0] number);
      req_item_type item;
      item.req_type = kind;
      item.record_number = number;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // inserts mostly use fresh numbers, other requests mostly hit stored ones
   function automatic logic [31:0] pick_number(input logic [1:0] kind);
      int r;
      int hit;
      logic [31:0] near;
      r = $urandom_range(99);
      hit = (kind == REQ_INSERT) ? 20 : 70;
      if (board.entries.size() != 0 && r < hit + 10) begin
         near = board.entries[$urandom_range(board.entries.size() - 1)];
         if (r < hit) return near;
         return r[0] ? near + 32'd1 : near - 32'd1;
      end
      if (r < hit + 15) begin
         case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [1:0] pick_kind(input mix_type mix);
      int r;
      r = $urandom_range(99);
      if (r < 5) return REQ_SPARE;
      if (r < 25) return REQ_LOOKUP;
      case (mix)
         MIX_FILL: return (r < 90) ? REQ_INSERT : REQ_REMOVE;
         MIX_DRAIN: return (r < 90) ? REQ_REMOVE : REQ_INSERT;
         default: return (r < 60) ? REQ_INSERT : REQ_REMOVE;
      endcase
   endfunction

   task automatic run_segment(input mix_type mix, input int length);
      logic [1:0] kind;
      repeat (length) begin
         kind = pick_kind(mix);
         send_request(kind, pick_number(kind));
      end
   endtask

   initial begin
      int phase;
      board = new(TABLE_DEPTH);
      req_idle_pct = 20;
      rsp_stall_pct = 77;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table, ends of the number range, duplicates, spare code
      send_request(REQ_LOOKUP, 32'd5);
      send_request(REQ_REMOVE, 32'd5);
      send_request(REQ_INSERT, 32'hffff_ffff);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h8000_0000);
      send_request(REQ_INSERT, 32'h7fff_ffff);
      send_request(REQ_INSERT, 32'h5555_aaaa);
      send_request(REQ_INSERT, 32'haaaa_5555);
      send_request(REQ_LOOKUP, 32'hffff_ffff);
      send_request(REQ_LOOKUP, 32'h0000_0000);
      send_request(REQ_SPARE, 32'h8000_0000);
      send_request(REQ_SPARE, 32'h8000_0001);
      send_request(REQ_LOOKUP, 32'h7fff_fffe);
      send_request(REQ_INSERT, 32'hffff_ffff);
      send_request(REQ_REMOVE, 32'h0000_0000);
      send_request(REQ_REMOVE, 32'h0000_0000);
      send_request(REQ_REMOVE, 32'hffff_ffff);
      send_request(REQ_REMOVE, 32'h5555_aaaa);
      send_request(REQ_LOOKUP, 32'haaaa_5555);

      // each phase fills the table past full, empties it, then mixes
      for (phase = 0; phase < 3; phase++) begin
         wait_all_responses();
         req_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 77 : 0;
         rsp_stall_pct = (phase == 0) ? 77 : (phase == 1) ? 20 : 0;
         run_segment(MIX_FILL, 170);
         run_segment(MIX_DRAIN, 170);
         run_segment(MIX_BALANCED, 80);
      end

      wait_all_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.report_leftovers();
      if (board.errors == 0) begin
         $display("sorted_unique_set_table_tb: done, clean");
      end else begin
         $display("sorted_unique_set_table_tb: done, errors");
      end
      $finish;
   end
endmodule
